[rtl/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and a rotate helper for the frame checksum and topic filter.
// ----------------------------------------------------------------------------
package cfc_pkg;

   localparam int HEADER_BYTES  = 26;
   localparam int DONE_W        = 13;
   localparam int END_W         = 17;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_TOPICS    = 4;

   localparam int POS_CSUM_HI   = 0;
   localparam int POS_CSUM_LO   = 1;
   localparam int POS_SUM_START = 2;
   localparam int POS_TOPIC_B3  = 18;
   localparam int POS_TOPIC_B2  = 19;
   localparam int POS_TOPIC_B1  = 20;
   localparam int POS_TOPIC_B0  = 21;
   localparam int POS_LEN_HI    = 24;
   localparam int POS_LEN_LO    = 25;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHECK_ENABLE = 3'd0,
      CSR_TOPIC_A      = 3'd1,
      CSR_TOPIC_B      = 3'd2,
      CSR_TOPIC_C      = 3'd3,
      CSR_TOPIC_D      = 3'd4,
      CSR_TOPIC_MASK   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0]       sum;
      logic [DONE_W-1:0] done;
      logic [15:0]       length;
      logic [31:0]       topic;
      logic [15:0]       csum;
      logic              overflow;
   } rec_type;

   typedef struct packed {
      logic        accepted;
      logic        checksum_ok;
      logic        topic_ok;
      logic        length_ok;
      logic [31:0] topic;
      logic [15:0] length;
      logic [15:0] sum;
   } rsp_type;

   function automatic logic [15:0] rotr16(input logic [15:0] v, input logic [3:0] k);
      logic [31:0] dbl;
      dbl = {v, v} >> k;
      return dbl[15:0];
   endfunction

endpackage

[rtl/cfc_fifo.sv]
// ----------------------------------------------------------------------------
// cfc_fifo
// Small register queue that decouples the two sides of the filter.
// ----------------------------------------------------------------------------
module cfc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/cfc_front.sv]
// ----------------------------------------------------------------------------
// cfc_front
// Per-byte stage: tracks position, captures header fields, runs the sum.
// ----------------------------------------------------------------------------
module cfc_front #(
   parameter int MAX_FRAME_BYTES = 1023
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       frame_byte,
   input  logic             last_byte,
   output logic             rec_push,
   output cfc_pkg::rec_type rec_data
);
   import cfc_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in, pos_next;
   logic [15:0]      sum_ff, sum_in;
   logic [15:0]      csum_ff, csum_in;
   logic [31:0]      topic_ff, topic_in;
   logic [15:0]      len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] done;

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      csum_in  = csum_ff;
      topic_in = topic_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      pos_next = (pos_ff <= MAX_POS) ? pos_ff + 1'b1 : pos_ff;
      done     = '0;
      rec_push = 1'b0;
      rec_data = '0;

      if (byte_valid) begin
         if (pos_ff < MAX_POS) begin
            if (pos_ff == POS_W'(POS_CSUM_HI)) csum_in[15:8]  = frame_byte;
            if (pos_ff == POS_W'(POS_CSUM_LO)) csum_in[7:0]   = frame_byte;
            if (pos_ff == POS_W'(POS_TOPIC_B3)) topic_in[31:24] = frame_byte;
            if (pos_ff == POS_W'(POS_TOPIC_B2)) topic_in[23:16] = frame_byte;
            if (pos_ff == POS_W'(POS_TOPIC_B1)) topic_in[15:8]  = frame_byte;
            if (pos_ff == POS_W'(POS_TOPIC_B0)) topic_in[7:0]   = frame_byte;
            if (pos_ff == POS_W'(POS_LEN_HI))  len_in[15:8]   = frame_byte;
            if (pos_ff == POS_W'(POS_LEN_LO))  len_in[7:0]    = frame_byte;
            if (pos_ff >= POS_W'(POS_SUM_START) &&
                END_W'(pos_ff) < END_W'(HEADER_BYTES) + END_W'(len_ff)) begin
               sum_in = {sum_ff[0], sum_ff[15:1]} + {8'h00, frame_byte};
            end
         end
         pos_in = pos_next;
         ovf_in = ovf_ff | (pos_next > MAX_POS);

         if (last_byte) begin
            done = (pos_next > MAX_POS) ? MAX_POS : pos_next;
            if (done < POS_W'(POS_SUM_START)) done = POS_W'(POS_SUM_START);
            rec_push          = 1'b1;
            rec_data.sum      = sum_in;
            rec_data.done     = DONE_W'(done);
            rec_data.length   = len_in;
            rec_data.topic    = topic_in;
            rec_data.csum     = csum_in;
            rec_data.overflow = ovf_in;
            // clear for the next frame
            pos_in   = '0;
            sum_in   = '0;
            csum_in  = '0;
            topic_in = '0;
            len_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         csum_ff  <= '0;
         topic_ff <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         csum_ff  <= csum_in;
         topic_ff <= topic_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

[rtl/cfc_back.sv]
// ----------------------------------------------------------------------------
// cfc_back
// Verdict stage: finishes the sum, checks checksum, topic and length.
// ----------------------------------------------------------------------------
module cfc_back #(
   parameter int TOPIC_ENTRIES   = 4,
   parameter int MAX_FRAME_BYTES = 1023
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [cfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             rec_empty,
   input  cfc_pkg::rec_type                 rec_data,
   output logic                             rec_pop,
   input  logic                             rsp_full,
   output logic                             rsp_push,
   output cfc_pkg::rsp_type                 rsp_data
);
   import cfc_pkg::*;

   logic                     check_en_ff;
   logic [31:0]              topic_tab_ff [TOPIC_ENTRIES];
   logic [TOPIC_ENTRIES-1:0] mask_ff;

   logic [END_W-1:0] end_val, done_ext, diff;
   logic [15:0]      sum;
   logic             csum_ok, topic_ok, len_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_en_ff <= 1'b1;
         mask_ff     <= '0;
         for (int e = 0; e < TOPIC_ENTRIES; e++) begin
            topic_tab_ff[e] <= '0;
         end
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CHECK_ENABLE) check_en_ff <= csr_write_data[0];
         if (csr_index == CSR_TOPIC_MASK)   mask_ff     <= csr_write_data[TOPIC_ENTRIES-1:0];
         for (int e = 0; e < TOPIC_ENTRIES; e++) begin
            if (csr_index == CSR_TOPIC_A + CSR_INDEX_W'(e)) begin
               topic_tab_ff[e] <= csr_write_data;
            end
         end
      end
   end

   always_comb begin
      end_val  = END_W'(HEADER_BYTES) + END_W'(rec_data.length);
      done_ext = END_W'(rec_data.done);
      diff     = end_val - done_ext;
      sum      = (done_ext < end_val) ? rotr16(rec_data.sum, diff[3:0]) : rec_data.sum;
      csum_ok  = (sum == rec_data.csum);
      topic_ok = 1'b0;
      for (int e = 0; e < TOPIC_ENTRIES; e++) begin
         if (mask_ff[e] && topic_tab_ff[e] == rec_data.topic) topic_ok = 1'b1;
      end
      len_ok = !rec_data.overflow &&
               (rec_data.length <= 16'(MAX_FRAME_BYTES - HEADER_BYTES));

      rec_pop              = !rec_empty && !rsp_full;
      rsp_push             = rec_pop;
      rsp_data.accepted    = (!check_en_ff || csum_ok) && topic_ok && len_ok;
      rsp_data.checksum_ok = csum_ok;
      rsp_data.topic_ok    = topic_ok;
      rsp_data.length_ok   = len_ok;
      rsp_data.topic       = rec_data.topic;
      rsp_data.length      = rec_data.length;
      rsp_data.sum         = sum;
   end

endmodule

[rtl/frame_checksum_topic_filter.sv]
// A result passes the frame queue and then the result queue to the result ports.
// Throughput: one byte per cycle while full is low; rotate-and-add sets the rate.
// Full rises only when the frame queue between the byte and verdict stages fills.
// Reset: synchronous; clears frame state and queues, loads register defaults.
// ----------------------------------------------------------------------------
// frame_checksum_topic_filter
// Top level: byte stage, frame queue, verdict stage and result queue.
// ----------------------------------------------------------------------------
module frame_checksum_topic_filter #(
   parameter int TOPIC_ENTRIES   = 4,
   parameter int MAX_FRAME_BYTES = 1023
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [7:0]                       req_frame_byte,
   input  logic                             req_last_byte,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_accepted,
   output logic                             rsp_checksum_ok,
   output logic                             rsp_topic_ok,
   output logic                             rsp_length_ok,
   output logic [31:0]                      rsp_frame_topic_out,
   output logic [15:0]                      rsp_data_length_out,
   output logic [15:0]                      rsp_computed_sum,
   input  logic                             csr_write_enable,
   input  logic [cfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfc_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import cfc_pkg::*;

   logic    rec_push, rec_full, rec_pop, rec_empty;
   rec_type rec_in, rec_out;
   logic    rsp_push, rsp_full;
   rsp_type rsp_in, rsp_out;

   cfc_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (push && !full),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .rec_push   (rec_push),
      .rec_data   (rec_in)
   );

   cfc_fifo #(
      .WIDTH($bits(rec_type)),
      .DEPTH(2)
   ) u_rec_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_out),
      .empty     (rec_empty)
   );

   assign full = rec_full;

   cfc_back #(
      .TOPIC_ENTRIES  (TOPIC_ENTRIES),
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rec_empty        (rec_empty),
      .rec_data         (rec_out),
      .rec_pop          (rec_pop),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp_data         (rsp_in)
   );

   cfc_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out),
      .empty     (empty)
   );

   assign rsp_accepted        = rsp_out.accepted;
   assign rsp_checksum_ok     = rsp_out.checksum_ok;
   assign rsp_topic_ok        = rsp_out.topic_ok;
   assign rsp_length_ok       = rsp_out.length_ok;
   assign rsp_frame_topic_out = rsp_out.topic;
   assign rsp_data_length_out = rsp_out.length;
   assign rsp_computed_sum    = rsp_out.sum;

endmodule
